FILE: hdl/char_lcd_cursor_terminal_top_defines.svh
// Assertion macros shared by the terminal RTL.
// Each checker compiles away when SYNTHESIS is defined.
`ifndef CHAR_LCD_CURSOR_TERMINAL_TOP_DEFINES_SVH
`define CHAR_LCD_CURSOR_TERMINAL_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Plain property on the clock, ignored while reset is high
`define CLCT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When pre holds, post must hold on the next cycle
`define CLCT_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define CLCT_ASSERT(label, clk, rst, prop, msg)
`define CLCT_ASSERT_NEXT(label, clk, rst, pre, post, msg)

`endif

`endif

FILE: hdl/clct_pkg.sv
package clct_pkg;

   // Sizes
   localparam int unsigned Columns    = 16;
   localparam int unsigned MaxResults = 32;
   localparam int unsigned ColW       = 6;
   localparam int unsigned ProgW      = 6;

   // Controller command bytes
   localparam logic [7:0] CmdRow0  = 8'h80;
   localparam logic [7:0] CmdRow1  = 8'hC0;
   localparam logic [7:0] CmdClear = 8'h01;
   localparam logic [7:0] CmdHome  = 8'h02;
   localparam logic [7:0] CmdLeft  = 8'h10;
   localparam logic [7:0] CmdRight = 8'h14;
   localparam logic [7:0] ChSpace  = 8'h20;

   // Special character codes
   localparam logic [7:0] ChCr = 8'h0D;
   localparam logic [7:0] ChLf = 8'h0A;
   localparam logic [7:0] ChBs = 8'h08;
   localparam logic [7:0] ChFf = 8'h0C;

   // Datapath action of one microcode step
   typedef enum logic [3:0] {
      ActWait,
      ActNone,
      ActRowCur,
      ActRowOther,
      ActRight,
      ActLeft,
      ActClear,
      ActHome,
      ActData,
      ActSpace,
      ActLoadOuter,
      ActLoadInner,
      ActDecOuter,
      ActDecInner,
      ActFinish
   } act_type;

   // Branch condition, sampled before the step's action
   typedef enum logic [3:0] {
      CondNext,
      CondAlways,
      CondPrevLf,
      CondPrevCr,
      CondRow1,
      CondColNotFull,
      CondColZero,
      CondOuterNz,
      CondInnerNz
   } cond_type;

   typedef struct packed {
      act_type           act;
      cond_type          cnd;
      logic [ProgW-1:0]  target;
   } ctl_word_type;

   // Program addresses
   localparam logic [ProgW-1:0] PcIdle      = 6'd0;
   localparam logic [ProgW-1:0] PcCr        = 6'd1;
   localparam logic [ProgW-1:0] PcLf        = 6'd3;
   localparam logic [ProgW-1:0] PcLfTest    = 6'd5;
   localparam logic [ProgW-1:0] PcRightLoop = 6'd6;
   localparam logic [ProgW-1:0] PcRightDec  = 6'd9;
   localparam logic [ProgW-1:0] PcLeftLoop  = 6'd11;
   localparam logic [ProgW-1:0] PcLeftWrap  = 6'd13;
   localparam logic [ProgW-1:0] PcLeftFill  = 6'd15;
   localparam logic [ProgW-1:0] PcLeftDec   = 6'd17;
   localparam logic [ProgW-1:0] PcBs        = 6'd19;
   localparam logic [ProgW-1:0] PcBsWrap1   = 6'd21;
   localparam logic [ProgW-1:0] PcBsFill1   = 6'd23;
   localparam logic [ProgW-1:0] PcBsSpace   = 6'd25;
   localparam logic [ProgW-1:0] PcBsPut     = 6'd27;
   localparam logic [ProgW-1:0] PcBsWrap2   = 6'd30;
   localparam logic [ProgW-1:0] PcBsFill2   = 6'd32;
   localparam logic [ProgW-1:0] PcFin       = 6'd34;
   localparam logic [ProgW-1:0] PcFf        = 6'd35;
   localparam logic [ProgW-1:0] PcPrint     = 6'd37;
   localparam logic [ProgW-1:0] PcPrintPut  = 6'd39;

   // Microcode ROM
   function automatic ctl_word_type ctl_rom(input logic [ProgW-1:0] pc);
      ctl_word_type w;
      unique case (pc)
         // idle, dispatch on the incoming character
         6'd0:  w = '{ActWait,      CondNext,       PcIdle};
         // carriage return
         6'd1:  w = '{ActNone,      CondPrevLf,     PcFin};
         6'd2:  w = '{ActRowCur,    CondAlways,     PcFin};
         // line feed: optional line start, then a full line of steps
         6'd3:  w = '{ActNone,      CondPrevCr,     PcLfTest};
         6'd4:  w = '{ActRowCur,    CondNext,       PcIdle};
         6'd5:  w = '{ActLoadOuter, CondRow1,       PcLeftLoop};
         6'd6:  w = '{ActRight,     CondNext,       PcIdle};
         6'd7:  w = '{ActNone,      CondColNotFull, PcRightDec};
         6'd8:  w = '{ActRowOther,  CondNext,       PcIdle};
         6'd9:  w = '{ActDecOuter,  CondOuterNz,    PcRightLoop};
         6'd10: w = '{ActNone,      CondAlways,     PcFin};
         6'd11: w = '{ActNone,      CondColZero,    PcLeftWrap};
         6'd12: w = '{ActLeft,      CondAlways,     PcLeftDec};
         6'd13: w = '{ActRowOther,  CondNext,       PcIdle};
         6'd14: w = '{ActLoadInner, CondNext,       PcIdle};
         6'd15: w = '{ActRight,     CondNext,       PcIdle};
         6'd16: w = '{ActDecInner,  CondInnerNz,    PcLeftFill};
         6'd17: w = '{ActDecOuter,  CondOuterNz,    PcLeftLoop};
         6'd18: w = '{ActNone,      CondAlways,     PcFin};
         // backspace: step left, print a space, step left
         6'd19: w = '{ActNone,      CondColZero,    PcBsWrap1};
         6'd20: w = '{ActLeft,      CondAlways,     PcBsSpace};
         6'd21: w = '{ActRowOther,  CondNext,       PcIdle};
         6'd22: w = '{ActLoadInner, CondNext,       PcIdle};
         6'd23: w = '{ActRight,     CondNext,       PcIdle};
         6'd24: w = '{ActDecInner,  CondInnerNz,    PcBsFill1};
         6'd25: w = '{ActNone,      CondColNotFull, PcBsPut};
         6'd26: w = '{ActRowOther,  CondNext,       PcIdle};
         6'd27: w = '{ActSpace,     CondNext,       PcIdle};
         6'd28: w = '{ActNone,      CondColZero,    PcBsWrap2};
         6'd29: w = '{ActLeft,      CondAlways,     PcFin};
         6'd30: w = '{ActRowOther,  CondNext,       PcIdle};
         6'd31: w = '{ActLoadInner, CondNext,       PcIdle};
         6'd32: w = '{ActRight,     CondNext,       PcIdle};
         6'd33: w = '{ActDecInner,  CondInnerNz,    PcBsFill2};
         // end of run: flush the held word marked last
         6'd34: w = '{ActFinish,    CondAlways,     PcIdle};
         // form feed
         6'd35: w = '{ActClear,     CondNext,       PcIdle};
         6'd36: w = '{ActHome,      CondAlways,     PcFin};
         // printable character, wrapping at a full line
         6'd37: w = '{ActNone,      CondColNotFull, PcPrintPut};
         6'd38: w = '{ActRowOther,  CondNext,       PcIdle};
         6'd39: w = '{ActData,      CondAlways,     PcFin};
         default: w = '{ActFinish,  CondAlways,     PcIdle};
      endcase
      return w;
   endfunction

endpackage

FILE: hdl/char_lcd_cursor_terminal_top.sv
// Channel   Direction  Handshake                 Word
// req       in         req_valid / req_stall     req_char_code
// rsp       out        rsp_valid / rsp_stall     rsp_lcd_byte, rsp_is_data,
//                                                rsp_long_wait, rsp_last_of_run
//
// A microcoded sequencer runs one character at a time, one ROM step per cycle
// while no stalled rsp freezes it. The step count of each character's ROM
// program sets how long its run lasts, and every run ends in the idle step;
// a line feed runs a full line of cursor steps after its optional line start.
// Synchronous reset clears the step counter, cursor, previous character, run
// count, held-word valid and output valid. A stalled rsp freezes the sequencer
// only when a held word must move into the occupied output register; req is taken only in the idle step.
`include "char_lcd_cursor_terminal_top_defines.svh"

module char_lcd_cursor_terminal_top #(
   parameter int unsigned COLUMNS = clct_pkg::Columns
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_lcd_byte,
   output logic       rsp_is_data,
   output logic       rsp_long_wait,
   output logic       rsp_last_of_run
);

   localparam int unsigned ColW  = clct_pkg::ColW;
   localparam int unsigned ProgW = clct_pkg::ProgW;
   localparam int unsigned LoopW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int unsigned CntW  = $clog2(clct_pkg::MaxResults + 1);

   // Sequencer and cursor state
   logic [ProgW-1:0] pc_ff, pc_in;
   logic             row_ff, row_in;
   logic [ColW-1:0]  col_ff, col_in;
   logic [7:0]       prev_ff, prev_in;
   logic [7:0]       char_ff, char_in;
   logic [LoopW-1:0] outer_ff, outer_in;
   logic [LoopW-1:0] inner_ff, inner_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;

   // One held word, so the final one can be marked last
   logic             pend_valid_ff, pend_valid_in;
   logic [7:0]       pend_byte_ff, pend_byte_in;
   logic             pend_data_ff, pend_data_in;
   logic             pend_long_ff, pend_long_in;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_data_ff, rsp_data_in;
   logic             rsp_long_ff, rsp_long_in;
   logic             rsp_last_ff, rsp_last_in;

   clct_pkg::ctl_word_type ctl;
   logic       emit_en;
   logic [7:0] emit_byte;
   logic       emit_data;
   logic       emit_long;
   logic       keep;
   logic       slot_free;
   logic       push_pend;
   logic       blocked;
   logic       jump;
   logic       col_full;
   logic       fin_go;
   logic [7:0] row_cur_cmd;
   logic [7:0] row_other_cmd;

   assign ctl           = clct_pkg::ctl_rom(pc_ff);
   assign col_full      = (col_ff == ColW'(COLUMNS));
   assign row_cur_cmd   = row_ff ? clct_pkg::CmdRow1 : clct_pkg::CmdRow0;
   assign row_other_cmd = row_ff ? clct_pkg::CmdRow0 : clct_pkg::CmdRow1;

   // Word produced by the current step
   always_comb begin
      emit_en   = 1'b0;
      emit_byte = clct_pkg::CmdHome;
      emit_data = 1'b0;
      emit_long = 1'b0;
      unique case (ctl.act)
         clct_pkg::ActRowCur: begin
            emit_en = 1'b1; emit_byte = row_cur_cmd; emit_long = 1'b1;
         end
         clct_pkg::ActRowOther: begin
            emit_en = 1'b1; emit_byte = row_other_cmd; emit_long = 1'b1;
         end
         clct_pkg::ActRight: begin
            emit_en = 1'b1; emit_byte = clct_pkg::CmdRight;
         end
         clct_pkg::ActLeft: begin
            emit_en = 1'b1; emit_byte = clct_pkg::CmdLeft;
         end
         clct_pkg::ActClear: begin
            emit_en = 1'b1; emit_byte = clct_pkg::CmdClear; emit_long = 1'b1;
         end
         clct_pkg::ActHome: begin
            emit_en = 1'b1; emit_byte = clct_pkg::CmdHome; emit_long = 1'b1;
         end
         clct_pkg::ActData: begin
            emit_en = 1'b1; emit_byte = char_ff; emit_data = 1'b1;
         end
         clct_pkg::ActSpace: begin
            emit_en = 1'b1; emit_byte = clct_pkg::ChSpace; emit_data = 1'b1;
         end
         default: begin
            emit_en = 1'b0;
         end
      endcase
   end

   // Branch condition on the state before this step
   always_comb begin
      unique case (ctl.cnd)
         clct_pkg::CondNext:       jump = 1'b0;
         clct_pkg::CondAlways:     jump = 1'b1;
         clct_pkg::CondPrevLf:     jump = (prev_ff == clct_pkg::ChLf);
         clct_pkg::CondPrevCr:     jump = (prev_ff == clct_pkg::ChCr);
         clct_pkg::CondRow1:       jump = row_ff;
         clct_pkg::CondColNotFull: jump = !col_full;
         clct_pkg::CondColZero:    jump = (col_ff == '0);
         clct_pkg::CondOuterNz:    jump = (outer_ff != '0);
         clct_pkg::CondInnerNz:    jump = (inner_ff != '0);
         default:                  jump = 1'b0;
      endcase
   end

   // Flow control between held word and output register
   assign keep      = (cnt_ff < CntW'(clct_pkg::MaxResults));
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign push_pend = pend_valid_ff &&
                      ((emit_en && keep) || (ctl.act == clct_pkg::ActFinish));
   assign blocked   = push_pend && !slot_free;
   assign fin_go    = (ctl.act == clct_pkg::ActFinish) && !blocked;

   // Next state
   always_comb begin
      pc_in         = pc_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      prev_in       = prev_ff;
      char_in       = char_ff;
      outer_in      = outer_ff;
      inner_in      = inner_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      pend_data_in  = pend_data_ff;
      pend_long_in  = pend_long_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_byte_in   = rsp_byte_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_long_in   = rsp_long_ff;
      rsp_last_in   = rsp_last_ff;

      if (!blocked) begin
         // move the held word out
         if (push_pend) begin
            rsp_valid_in  = 1'b1;
            rsp_byte_in   = pend_byte_ff;
            rsp_data_in   = pend_data_ff;
            rsp_long_in   = pend_long_ff;
            rsp_last_in   = (ctl.act == clct_pkg::ActFinish);
            pend_valid_in = 1'b0;
         end
         // hold the new word; past the run limit it is dropped
         if (emit_en && keep) begin
            pend_valid_in = 1'b1;
            pend_byte_in  = emit_byte;
            pend_data_in  = emit_data;
            pend_long_in  = emit_long;
            cnt_in        = cnt_ff + CntW'(1);
         end

         pc_in = jump ? ctl.target : pc_ff + ProgW'(1);

         unique case (ctl.act)
            clct_pkg::ActWait: begin
               pc_in = pc_ff;
               if (req_valid) begin
                  char_in = req_char_code;
                  cnt_in  = '0;
                  priority if (req_char_code == clct_pkg::ChCr) begin
                     pc_in = clct_pkg::PcCr;
                  end else if (req_char_code == clct_pkg::ChLf) begin
                     pc_in = clct_pkg::PcLf;
                  end else if (req_char_code == clct_pkg::ChBs) begin
                     pc_in = clct_pkg::PcBs;
                  end else if (req_char_code == clct_pkg::ChFf) begin
                     pc_in = clct_pkg::PcFf;
                  end else begin
                     pc_in = clct_pkg::PcPrint;
                  end
               end
            end
            clct_pkg::ActRowCur: begin
               col_in = '0;
            end
            clct_pkg::ActRowOther: begin
               row_in = !row_ff;
               col_in = '0;
            end
            clct_pkg::ActRight: begin
               col_in = col_ff + ColW'(1);
            end
            clct_pkg::ActLeft: begin
               col_in = col_ff - ColW'(1);
            end
            clct_pkg::ActHome: begin
               row_in = 1'b0;
               col_in = '0;
            end
            clct_pkg::ActData, clct_pkg::ActSpace: begin
               col_in = col_ff + ColW'(1);
            end
            clct_pkg::ActLoadOuter: begin
               outer_in = LoopW'(COLUMNS - 1);
            end
            clct_pkg::ActLoadInner: begin
               inner_in = LoopW'(COLUMNS - 2);
            end
            clct_pkg::ActDecOuter: begin
               outer_in = outer_ff - LoopW'(1);
            end
            clct_pkg::ActDecInner: begin
               inner_in = inner_ff - LoopW'(1);
            end
            clct_pkg::ActFinish: begin
               prev_in = char_ff;
            end
            default: begin
               col_in = col_ff;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= clct_pkg::PcIdle;
         row_ff        <= 1'b0;
         col_ff        <= '0;
         prev_ff       <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         prev_ff       <= prev_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload and loop registers
   always_ff @(posedge clock) begin
      char_ff      <= char_in;
      outer_ff     <= outer_in;
      inner_ff     <= inner_in;
      pend_byte_ff <= pend_byte_in;
      pend_data_ff <= pend_data_in;
      pend_long_ff <= pend_long_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_long_ff  <= rsp_long_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_stall       = (pc_ff != clct_pkg::PcIdle);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_lcd_byte    = rsp_byte_ff;
   assign rsp_is_data     = rsp_data_ff;
   assign rsp_long_wait   = rsp_long_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // Checks
   `CLCT_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CntW'(clct_pkg::MaxResults), "run count past limit")
   `CLCT_ASSERT(a_col_range, clock, reset, (pc_ff == clct_pkg::PcIdle) |-> (col_ff <= ColW'(COLUMNS)), "column out of range")
   `CLCT_ASSERT(a_pend_counted, clock, reset, pend_valid_ff |-> (cnt_ff != '0), "held word not counted")
   `CLCT_ASSERT_NEXT(a_fin_drain, clock, reset, fin_go, !pend_valid_ff && (pc_ff == clct_pkg::PcIdle), "run end left a word held")

endmodule

FILE: tb/sv/lcd_run_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the LCD terminal, predicts the run of controller
// words for every character taken and compares each word leaving the block
module lcd_run_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_lcd_byte,
   input  logic        rsp_is_data,
   input  logic        rsp_long_wait,
   input  logic        rsp_last_of_run,
   output int unsigned mismatch_count,
   output int unsigned words_pending,
   output int unsigned words_checked
);

   typedef struct packed {
      logic [7:0] code;
      logic       is_data;
      logic       long_wait;
      logic       last;
   } lcd_word_type;

   // Words still owed by the block, oldest first
   lcd_word_type expected_words[$];
   // Run being built for the current character
   lcd_word_type run_words[$];
   int           run_len;

   // Shadow of the cursor and the previous character
   logic                      cur_row;
   logic [clct_pkg::ColW-1:0] cur_col;
   logic [7:0]                prev_code;

   int unsigned fail_total;
   int unsigned checked_total;

   // Only the first MaxResults words of a run leave the block
   function automatic void emit_word(input logic [7:0] b, input logic data,
                                     input logic slow);
      if (run_len < clct_pkg::MaxResults)
         run_words.push_back('{b, data, slow, 1'b0});
      run_len++;
   endfunction

   // Cursor moves are fast, every other command is slow
   function automatic void send_command(input logic [7:0] cmd);
      emit_word(cmd, 1'b0, !(cmd == clct_pkg::CmdLeft || cmd == clct_pkg::CmdRight));
   endfunction

   function automatic void to_other_row();
      if (!cur_row) begin
         send_command(clct_pkg::CmdRow1);
         cur_row = 1'b1;
      end else begin
         send_command(clct_pkg::CmdRow0);
         cur_row = 1'b0;
      end
   endfunction

   function automatic void cursor_right();
      send_command(clct_pkg::CmdRight);
      cur_col = cur_col + 1'b1;
      if (cur_col == clct_pkg::Columns) begin
         cur_col = '0;
         to_other_row();
      end
   endfunction

   // Leftwards from column 0 goes round via the other line's start
   function automatic void cursor_left();
      int i;
      if (cur_col == 0) begin
         to_other_row();
         for (i = 0; i < clct_pkg::Columns - 1; i++)
            cursor_right();
      end else begin
         cur_col = cur_col - 1'b1;
         send_command(clct_pkg::CmdLeft);
      end
   endfunction

   // Printing into a full line wraps first
   function automatic void write_char(input logic [7:0] c);
      if (cur_col == clct_pkg::Columns) begin
         cur_col = '0;
         to_other_row();
      end
      emit_word(c, 1'b1, 1'b0);
      cur_col = cur_col + 1'b1;
   endfunction

   function automatic void predict_char(input logic [7:0] c);
      int           i;
      lcd_word_type w;
      run_words.delete();
      run_len = 0;
      if (c == clct_pkg::ChCr) begin
         // CR straight after LF is swallowed
         if (prev_code != clct_pkg::ChLf) begin
            send_command(cur_row ? clct_pkg::CmdRow1 : clct_pkg::CmdRow0);
            cur_col = '0;
         end
      end else if (c == clct_pkg::ChLf) begin
         if (prev_code != clct_pkg::ChCr) begin
            send_command(cur_row ? clct_pkg::CmdRow1 : clct_pkg::CmdRow0);
            cur_col = '0;
         end
         // a full line of steps lands on the other line; direction is fixed
         // by the line the feed starts on
         if (!cur_row) begin
            for (i = 0; i < clct_pkg::Columns; i++)
               cursor_right();
         end else begin
            for (i = 0; i < clct_pkg::Columns; i++)
               cursor_left();
         end
      end else if (c == clct_pkg::ChBs) begin
         cursor_left();
         write_char(clct_pkg::ChSpace);
         cursor_left();
      end else if (c == clct_pkg::ChFf) begin
         send_command(clct_pkg::CmdClear);
         send_command(clct_pkg::CmdHome);
         cur_row = 1'b0;
         cur_col = '0;
      end else begin
         write_char(c);
      end
      prev_code = c;
      if (run_words.size() > 0) begin
         w = run_words.pop_back();
         w.last = 1'b1;
         run_words.push_back(w);
      end
      foreach (run_words[k])
         expected_words.push_back(run_words[k]);
   endfunction

   // Sample both channels at the edge that accepts a word
   always @(posedge clock) begin : watch
      lcd_word_type want;
      lcd_word_type got;
      if (reset) begin
         cur_row       = 1'b0;
         cur_col       = '0;
         prev_code     = 8'h00;
         fail_total    = 0;
         checked_total = 0;
         expected_words.delete();
      end else begin
         if (req_valid && !req_stall)
            predict_char(req_char_code);
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_lcd_byte, rsp_is_data, rsp_long_wait, rsp_last_of_run};
            if (expected_words.size() == 0) begin
               if (fail_total < 10)
                  $display("tb: unexpected word byte=%02h data=%0b long=%0b last=%0b",
                           got.code, got.is_data, got.long_wait, got.last);
               fail_total++;
            end else begin
               want = expected_words.pop_front();
               if (got.code !== want.code || got.is_data !== want.is_data ||
                   got.long_wait !== want.long_wait || got.last !== want.last) begin
                  if (fail_total < 10) begin
                     $display("tb: mismatch exp byte=%02h data=%0b long=%0b last=%0b",
                              want.code, want.is_data, want.long_wait, want.last);
                     $display("tb:          got byte=%02h data=%0b long=%0b last=%0b",
                              got.code, got.is_data, got.long_wait, got.last);
                  end
                  fail_total++;
               end
               checked_total++;
            end
         end
      end
      mismatch_count <= fail_total;
      words_pending  <= expected_words.size();
      words_checked  <= checked_total;
   end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int unsigned WatchdogLimit = 20000;
   localparam int unsigned HoldLen       = 300;
   // longest run is a line feed on the lower line
   localparam int unsigned DrainCycles   = 2 * clct_pkg::Columns * clct_pkg::Columns + 64;

   typedef enum logic [2:0] {
      PhQuiet,
      PhSendIdle,
      PhRecvStall,
      PhBoth,
      PhHold
   } phase_type;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic [7:0] req_char_code = 8'h00;
   logic       rsp_stall     = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_lcd_byte;
   logic       rsp_is_data;
   logic       rsp_long_wait;
   logic       rsp_last_of_run;

   phase_type   phase = PhQuiet;
   int unsigned chars_sent = 0;
   int unsigned idle_cycles = 0;
   int unsigned hold_left = 0;
   logic        hold_done = 1'b0;

   int unsigned mismatch_count;
   int unsigned words_pending;
   int unsigned words_checked;

   always #6 clock = ~clock;

   char_lcd_cursor_terminal_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_lcd_byte    (rsp_lcd_byte),
      .rsp_is_data     (rsp_is_data),
      .rsp_long_wait   (rsp_long_wait),
      .rsp_last_of_run (rsp_last_of_run)
   );

   lcd_run_checker run_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_lcd_byte    (rsp_lcd_byte),
      .rsp_is_data     (rsp_is_data),
      .rsp_long_wait   (rsp_long_wait),
      .rsp_last_of_run (rsp_last_of_run),
      .mismatch_count  (mismatch_count),
      .words_pending   (words_pending),
      .words_checked   (words_checked)
   );

   // Receiver: one long hold-off on entering the hold phase, random stalls in the PhRecvStall and PhBoth phases
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (phase == PhHold && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HoldLen - 1;
         hold_done <= 1'b1;
      end else if (phase == PhRecvStall) begin
         rsp_stall <= ($urandom_range(0, 99) < 78);
      end else if (phase == PhBoth) begin
         rsp_stall <= ($urandom_range(0, 99) < 24);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WatchdogLimit) begin
         $display("tb: watchdog expired, %0d words still owed", words_pending);
         $display("tb: done, errors");
         $finish;
      end
   end

   // Offer one character, with random idle cycles ahead of it in the PhSendIdle and PhBoth phases
   task automatic send_char(input phase_type ph, input logic [7:0] code);
      int unsigned idle_pct;
      idle_pct = (ph == PhSendIdle) ? 78 : (ph == PhBoth) ? 24 : 0;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= code;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      chars_sent++;
   endtask

   // Mostly printable text with line ends, erases and clears mixed in
   task automatic run_phase(input phase_type ph, input int unsigned count);
      int unsigned i;
      int unsigned pick;
      phase <= ph;
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            send_char(ph, 8'($urandom_range(8'h20, 8'h7E)));
         end else if (pick < 64) begin
            send_char(ph, clct_pkg::ChCr);
            if ($urandom_range(0, 1))
               send_char(ph, clct_pkg::ChLf);
         end else if (pick < 70) begin
            send_char(ph, clct_pkg::ChLf);
         end else if (pick < 79) begin
            send_char(ph, clct_pkg::ChBs);
         end else if (pick < 82) begin
            send_char(ph, clct_pkg::ChFf);
         end else begin
            send_char(ph, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      logic [7:0]  directed_codes[$];
      int unsigned errors;

      // printable extremes, paired and lone line ends, erase with both wraps,
      // full-line wrap, clear, and near-miss control codes
      directed_codes = '{
         clct_pkg::ChFf, 8'h41, 8'h00, 8'hFF, 8'h7F, 8'h80, 8'h55, 8'hAA,
         clct_pkg::ChCr, clct_pkg::ChLf, clct_pkg::ChCr, clct_pkg::ChLf,
         clct_pkg::ChLf, clct_pkg::ChCr,
         clct_pkg::ChFf, clct_pkg::ChBs, 8'h5A, clct_pkg::ChBs, 8'h5A, 8'h59,
         clct_pkg::ChBs, clct_pkg::ChBs,
         8'h0B, 8'h09, 8'h0E
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_codes[k])
         send_char(PhQuiet, directed_codes[k]);

      run_phase(PhQuiet, 80);
      run_phase(PhSendIdle, 80);
      run_phase(PhRecvStall, 80);
      run_phase(PhBoth, 80);
      run_phase(PhHold, 40);
      run_phase(PhQuiet, 60);
      req_valid <= 1'b0;
      phase     <= PhQuiet;

      // let every owed word arrive, then watch for strays
      while (words_pending != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      errors = mismatch_count + words_pending;
      $display("tb: %0d characters taken, %0d LCD words compared", chars_sent,
               words_checked);
      $display("tb: phases covered free flow, sender gaps, receiver stalls, both, hold-off");
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: %0d failures", errors);
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

FILE: char_lcd_cursor_terminal_top.f
+incdir+hdl
hdl/clct_pkg.sv
hdl/char_lcd_cursor_terminal_top.sv
tb/sv/lcd_run_checker.sv
tb/sv/tb.sv
